// ===== src/cheb_pkg.sv =====
// shared types and constants for the chebyshev series evaluator
package cheb_pkg;

  // fixed field widths
  localparam int DATA_W     = 32;
  localparam int COEF_IDX_W = 6;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_COUNT  = 2'd2
  } cfg_reg_t;

  // item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // saturation bounds
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MULW,
    S_FINW,
    S_MULT,
    S_MULG,
    S_FING,
    S_DONE
  } state_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_WX,
    MUL_WT,
    MUL_GT
  } mul_sel_t;

  // round, saturate and add step applied to the registered product
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_W,
    FIN_T,
    FIN_G
  } fin_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     mem_we;
    logic     load_x;
    logic     clear;
    logic     acc_init;
    mul_sel_t mul;
    fin_sel_t fin;
    logic     out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== src/cheb_dpath.sv =====
// datapath: config registers, coefficient memory, shared multiplier, accumulator, output register
module cheb_dpath #(
  parameter int MAX_COEFFS = 64,
  parameter int FRAC_BITS  = 24,
  parameter int ADDR_W     = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1,
  parameter int CNT_W      = $clog2(MAX_COEFFS + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cheb_pkg::dp_cmd_t                      ctl,
  input  logic [ADDR_W-1:0]                      rd_addr,
  input  logic [cheb_pkg::COEF_IDX_W-1:0]        coef_index,
  input  logic signed [cheb_pkg::DATA_W-1:0]     coef_value,
  input  logic signed [cheb_pkg::DATA_W-1:0]     x_value,
  input  logic                                   cfg_we,
  input  logic [cheb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cheb_pkg::DATA_W-1:0]            cfg_data,
  input  logic                                   out_stall,
  output logic [CNT_W-1:0]                       coef_num,
  output cheb_pkg::dp_stat_t                     stat,
  output logic                                   out_valid,
  output logic signed [cheb_pkg::DATA_W-1:0]     series_value,
  output logic                                   saturated
);

  localparam int DW = cheb_pkg::DATA_W;
  localparam int EW = ((ADDR_W > cheb_pkg::COEF_IDX_W) ? ADDR_W : cheb_pkg::COEF_IDX_W) + 1;
  localparam int MW = ((CNT_W > cheb_pkg::COUNT_W) ? CNT_W : cheb_pkg::COUNT_W) + 1;
  localparam logic signed [DW-1:0] T0_ONE    = DW'(64'd1 << FRAC_BITS);
  localparam logic signed [DW-1:0] SCALE_RST = DW'(64'd1 << (FRAC_BITS + 1));
  localparam logic signed [63:0]   RND_HALF  = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [DW-1:0]         scale_factor;
  logic signed [DW-1:0]         offset_term;
  logic [cheb_pkg::COUNT_W-1:0] coeff_count;

  logic signed [DW-1:0] mem [MAX_COEFFS];
  logic signed [DW-1:0] gdata;
  logic                 wr_ok;
  logic [ADDR_W-1:0]    wr_addr;

  logic signed [DW-1:0] x_reg;
  logic signed [DW-1:0] w;
  logic signed [DW-1:0] tcur;
  logic signed [DW-1:0] tprev;
  logic signed [DW-1:0] acc;
  logic                 flag;

  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [63:0]   prod;

  logic signed [63:0]   rnd_sh;
  logic signed [DW-1:0] rnd_val;
  logic                 rnd_flag;
  logic signed [DW-1:0] add_op;
  logic                 add_sub;
  logic signed [DW:0]   sum;
  logic signed [DW-1:0] fin_res;
  logic                 sum_flag;
  logic signed [DW:0]   u_wide;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_RST;
      offset_term  <= '0;
      coeff_count  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cheb_pkg::CFG_SCALE:  scale_factor <= cfg_data;
        cheb_pkg::CFG_OFFSET: offset_term  <= cfg_data;
        cheb_pkg::CFG_COUNT:  coeff_count  <= cfg_data[cheb_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // count in use, limited to the store depth
  always_comb begin
    if (MW'(coeff_count) > MW'(MAX_COEFFS)) begin
      coef_num = CNT_W'(MAX_COEFFS);
    end else begin
      coef_num = CNT_W'(coeff_count);
    end
  end

  // coefficient memory, loads beyond the depth are dropped
  assign wr_ok   = EW'(coef_index) < EW'(MAX_COEFFS);
  assign wr_addr = ADDR_W'(coef_index);

  always_ff @(posedge clk) begin
    if (ctl.mem_we && wr_ok) begin
      mem[wr_addr] <= coef_value;
    end
    gdata <= mem[rd_addr];
  end

  // shared multiplier with registered product
  always_comb begin
    case (ctl.mul)
      cheb_pkg::MUL_WX: begin
        mul_a = scale_factor;
        mul_b = x_reg;
      end
      cheb_pkg::MUL_WT: begin
        mul_a = w;
        mul_b = tcur;
      end
      cheb_pkg::MUL_GT: begin
        mul_a = gdata;
        mul_b = tcur;
      end
      default: begin
        mul_a = w;
        mul_b = tcur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // round to nearest (ties up) and saturate the product
  always_comb begin
    rnd_sh   = (prod + RND_HALF) >>> FRAC_BITS;
    rnd_flag = 1'b0;
    if (rnd_sh > 64'(cheb_pkg::S32_MAX)) begin
      rnd_val  = cheb_pkg::S32_MAX;
      rnd_flag = 1'b1;
    end else if (rnd_sh < 64'(cheb_pkg::S32_MIN)) begin
      rnd_val  = cheb_pkg::S32_MIN;
      rnd_flag = 1'b1;
    end else begin
      rnd_val = DW'(rnd_sh);
    end
  end

  // add or subtract the second operand and saturate
  always_comb begin
    case (ctl.fin)
      cheb_pkg::FIN_W: begin
        add_op  = offset_term;
        add_sub = 1'b0;
      end
      cheb_pkg::FIN_T: begin
        add_op  = tprev;
        add_sub = 1'b1;
      end
      cheb_pkg::FIN_G: begin
        add_op  = acc;
        add_sub = 1'b0;
      end
      default: begin
        add_op  = acc;
        add_sub = 1'b0;
      end
    endcase
    if (add_sub) begin
      sum = (DW+1)'(rnd_val) - (DW+1)'(add_op);
    end else begin
      sum = (DW+1)'(rnd_val) + (DW+1)'(add_op);
    end
    sum_flag = 1'b0;
    if (sum > (DW+1)'(cheb_pkg::S32_MAX)) begin
      fin_res  = cheb_pkg::S32_MAX;
      sum_flag = 1'b1;
    end else if (sum < (DW+1)'(cheb_pkg::S32_MIN)) begin
      fin_res  = cheb_pkg::S32_MIN;
      sum_flag = 1'b1;
    end else begin
      fin_res = DW'(sum);
    end
    // u = (w + 1) / 2 with floor
    u_wide = ((DW+1)'(fin_res) + (DW+1)'(1)) >>> 1;
  end

  // recurrence and accumulator registers
  always_ff @(posedge clk) begin
    if (ctl.load_x) begin
      x_reg <= x_value;
    end
    if (ctl.clear) begin
      acc  <= '0;
      flag <= 1'b0;
    end
    if (ctl.acc_init) begin
      acc <= gdata;
    end
    case (ctl.fin)
      cheb_pkg::FIN_W: begin
        w     <= fin_res;
        tcur  <= DW'(u_wide);
        tprev <= T0_ONE;
        flag  <= flag | rnd_flag | sum_flag;
      end
      cheb_pkg::FIN_T: begin
        tprev <= tcur;
        tcur  <= fin_res;
        flag  <= flag | rnd_flag | sum_flag;
      end
      cheb_pkg::FIN_G: begin
        acc  <= fin_res;
        flag <= flag | rnd_flag | sum_flag;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      series_value <= acc;
      saturated    <= flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid && out_stall;

endmodule

// ===== src/cheb_ctrl.sv =====
// controller: sequences loads and the chebyshev recurrence over the coefficients
module cheb_ctrl #(
  parameter int MAX_COEFFS = 64,
  parameter int ADDR_W     = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1,
  parameter int CNT_W      = $clog2(MAX_COEFFS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               cmd,
  output logic               in_stall,
  input  logic [CNT_W-1:0]   coef_num,
  input  cheb_pkg::dp_stat_t stat,
  output cheb_pkg::dp_cmd_t  ctl,
  output logic [ADDR_W-1:0]  rd_addr
);

  localparam int KW = CNT_W + 1;

  cheb_pkg::state_t state;
  cheb_pkg::state_t state_next;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] k_next;
  logic             more;
  logic             k_ge2;

  // coefficient index and the loop tests on it
  assign more    = (KW'(k) + KW'(1)) < KW'(coef_num);
  assign k_ge2   = KW'(k) >= KW'(2);
  assign rd_addr = k[ADDR_W-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cheb_pkg::S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    k_next     = k;
    ctl        = '0;
    in_stall   = 1'b1;
    case (state)
      cheb_pkg::S_IDLE: begin
        in_stall = 1'b0;
        k_next   = '0;
        if (in_valid) begin
          if (cmd == cheb_pkg::CMD_LOAD) begin
            ctl.mem_we = 1'b1;
          end else begin
            ctl.load_x = 1'b1;
            ctl.clear  = 1'b1;
            if (coef_num == '0) begin
              state_next = cheb_pkg::S_DONE;
            end else begin
              state_next = cheb_pkg::S_MULW;
            end
          end
        end
      end
      // w product; g0 taken straight into the accumulator
      cheb_pkg::S_MULW: begin
        ctl.mul      = cheb_pkg::MUL_WX;
        ctl.acc_init = 1'b1;
        k_next       = CNT_W'(1);
        state_next   = cheb_pkg::S_FINW;
      end
      cheb_pkg::S_FINW: begin
        ctl.fin = cheb_pkg::FIN_W;
        if (coef_num == CNT_W'(1)) begin
          state_next = cheb_pkg::S_DONE;
        end else if (more) begin
          state_next = cheb_pkg::S_MULT;
        end else begin
          state_next = cheb_pkg::S_MULG;
        end
      end
      // w * T(k) for the next term, finish the previous g * T
      cheb_pkg::S_MULT: begin
        ctl.mul = cheb_pkg::MUL_WT;
        if (k_ge2) begin
          ctl.fin = cheb_pkg::FIN_G;
        end
        state_next = cheb_pkg::S_MULG;
      end
      // g(k) * T(k), finish T(k+1) when it is needed
      cheb_pkg::S_MULG: begin
        ctl.mul = cheb_pkg::MUL_GT;
        if (more) begin
          ctl.fin    = cheb_pkg::FIN_T;
          k_next     = CNT_W'(KW'(k) + KW'(1));
          state_next = cheb_pkg::S_MULT;
        end else begin
          state_next = cheb_pkg::S_FING;
        end
      end
      cheb_pkg::S_FING: begin
        ctl.fin    = cheb_pkg::FIN_G;
        state_next = cheb_pkg::S_DONE;
      end
      // hand the result to the output register once it is free
      cheb_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          ctl.out_load = 1'b1;
          k_next       = '0;
          state_next   = cheb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cheb_pkg::S_IDLE;
        k_next     = '0;
      end
    endcase
  end

  // result never overwrites one that is still waiting
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !stat.out_busy)
    else $error("output register loaded while a result is held");

  // a recurrence step only finishes a w * T product
  a_t_after_wt: assert property (@(posedge clk) disable iff (rst)
    (ctl.fin == cheb_pkg::FIN_T) |-> ($past(state) == cheb_pkg::S_MULT))
    else $error("recurrence finished without a w * T product");

  // loop index stays inside the coefficients in use
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == cheb_pkg::S_MULT || state == cheb_pkg::S_MULG) |->
      (k != '0 && KW'(k) < KW'(coef_num)))
    else $error("coefficient index out of range");

  // after a g * T product either the loop goes on or the last term is finished
  a_mulg_next: assert property (@(posedge clk) disable iff (rst)
    (state == cheb_pkg::S_MULG) |=>
      (state == cheb_pkg::S_MULT || state == cheb_pkg::S_FING))
    else $error("bad sequence after g * T product");

endmodule

// ===== src/chebyshev_series_evaluator_top.sv =====
// Chebyshev series evaluator: load items fill the coefficient memory, evaluate items return one sum.
// A load writes the memory and leaves the controller idle for the next item. An evaluate with
// n coefficients in use places its result in the output register when the recurrence is done,
// and the next item is taken after that, later while a held result blocks the register.
// The single 32x32 multiplier is shared, used twice per coefficient after g0 (w*T and g*T).
// Synchronous active-high reset: scale 2.0, offset 0, count 0, controller idle, output empty;
// the coefficient memory is not cleared and holds nothing defined until written.
module chebyshev_series_evaluator_top #(
  parameter int MAX_COEFFS = 64,
  parameter int FRAC_BITS  = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   cmd,
  input  logic [cheb_pkg::COEF_IDX_W-1:0]        coef_index,
  input  logic signed [cheb_pkg::DATA_W-1:0]     coef_value,
  input  logic signed [cheb_pkg::DATA_W-1:0]     x_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cheb_pkg::DATA_W-1:0]     series_value,
  output logic                                   saturated,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cheb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cheb_pkg::DATA_W-1:0]            cfg_data
);

  localparam int ADDR_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int CNT_W  = $clog2(MAX_COEFFS + 1);

  cheb_pkg::dp_cmd_t  ctl;
  cheb_pkg::dp_stat_t stat;
  logic [CNT_W-1:0]   coef_num;
  logic [ADDR_W-1:0]  rd_addr;
  logic               cfg_we;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  cheb_ctrl #(
    .MAX_COEFFS (MAX_COEFFS),
    .ADDR_W     (ADDR_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .coef_num (coef_num),
    .stat     (stat),
    .ctl      (ctl),
    .rd_addr  (rd_addr)
  );

  cheb_dpath #(
    .MAX_COEFFS (MAX_COEFFS),
    .FRAC_BITS  (FRAC_BITS),
    .ADDR_W     (ADDR_W),
    .CNT_W      (CNT_W)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .rd_addr      (rd_addr),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .x_value      (x_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_stall    (out_stall),
    .coef_num     (coef_num),
    .stat         (stat),
    .out_valid    (out_valid),
    .series_value (series_value),
    .saturated    (saturated)
  );

endmodule
